[rtl/rvienc_pkg.sv]
// shared types, constants and lookup functions of the rv32i instruction encoder
`default_nettype none

package rvienc_pkg;

	// base opcodes
	localparam logic [6:0] OP_REG    = 7'b0110011;
	localparam logic [6:0] OP_IMM    = 7'b0010011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_LUI    = 7'b0110111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;
	localparam logic [6:0] OP_JAL    = 7'b1101111;

	// funct7 values
	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;

	// funct3 values
	localparam logic [2:0] F3_0 = 3'd0;
	localparam logic [2:0] F3_1 = 3'd1;
	localparam logic [2:0] F3_2 = 3'd2;
	localparam logic [2:0] F3_3 = 3'd3;
	localparam logic [2:0] F3_4 = 3'd4;
	localparam logic [2:0] F3_5 = 3'd5;
	localparam logic [2:0] F3_6 = 3'd6;
	localparam logic [2:0] F3_7 = 3'd7;

	// mnemonic codes
	typedef enum logic [5:0] {
		MN_ADD, MN_SUB, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_SRA, MN_OR, MN_AND,
		MN_ADDI, MN_SLTI, MN_SLTIU, MN_XORI, MN_ORI, MN_ANDI, MN_SLLI, MN_SRLI, MN_SRAI,
		MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU,
		MN_JALR,
		MN_SB, MN_SH, MN_SW,
		MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
		MN_LUI, MN_AUIPC,
		MN_JAL
	} mnem_t;

	// instruction layouts
	typedef enum logic [2:0] {
		FMT_R, FMT_SHIFT, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J, FMT_BAD
	} fmt_t;

	// one instruction to encode
	typedef struct packed {
		logic [5:0]         action;
		logic [4:0]         dest_reg;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic signed [31:0] immediate;
		logic signed [31:0] label_offset;
		logic               target_is_label;
	} in_item_t;

	// one encoded result
	typedef struct packed {
		logic [31:0] machine_word;
		logic        bad_mnemonic;
	} out_item_t;

	// layout of a mnemonic
	function automatic fmt_t get_format(input mnem_t code);
		fmt_t f;
		case (code) inside
			[MN_ADD:MN_AND]:   f = FMT_R;
			[MN_SLLI:MN_SRAI]: f = FMT_SHIFT;
			[MN_ADDI:MN_ANDI],
			[MN_LB:MN_JALR]:   f = FMT_I;
			[MN_SB:MN_SW]:     f = FMT_S;
			[MN_BEQ:MN_BGEU]:  f = FMT_B;
			MN_LUI, MN_AUIPC:  f = FMT_U;
			MN_JAL:            f = FMT_J;
			default:           f = FMT_BAD;
		endcase
		return f;
	endfunction

	// major opcode of a mnemonic
	function automatic logic [6:0] get_opcode(input mnem_t code);
		logic [6:0] op;
		case (code) inside
			[MN_ADD:MN_AND]:   op = OP_REG;
			[MN_ADDI:MN_SRAI]: op = OP_IMM;
			[MN_LB:MN_LHU]:    op = OP_LOAD;
			MN_JALR:           op = OP_JALR;
			[MN_SB:MN_SW]:     op = OP_STORE;
			[MN_BEQ:MN_BGEU]:  op = OP_BRANCH;
			MN_LUI:            op = OP_LUI;
			MN_AUIPC:          op = OP_AUIPC;
			MN_JAL:            op = OP_JAL;
			default:           op = '0;
		endcase
		return op;
	endfunction

	// funct3 of a mnemonic
	function automatic logic [2:0] get_funct3(input mnem_t code);
		logic [2:0] f3;
		case (code)
			MN_SLL, MN_SLLI, MN_LH, MN_SH, MN_BNE:         f3 = F3_1;
			MN_SLT, MN_SLTI, MN_LW, MN_SW:                 f3 = F3_2;
			MN_SLTU, MN_SLTIU:                             f3 = F3_3;
			MN_XOR, MN_XORI, MN_LBU, MN_BLT:               f3 = F3_4;
			MN_SRL, MN_SRA, MN_SRLI, MN_SRAI, MN_LHU,
			MN_BGE:                                        f3 = F3_5;
			MN_OR, MN_ORI, MN_BLTU:                        f3 = F3_6;
			MN_AND, MN_ANDI, MN_BGEU:                      f3 = F3_7;
			default:                                       f3 = F3_0;
		endcase
		return f3;
	endfunction

	// funct7 of a mnemonic, alternate only for subtract and arithmetic shifts
	function automatic logic [6:0] get_funct7(input mnem_t code);
		logic [6:0] f7;
		case (code)
			MN_SUB, MN_SRA, MN_SRAI: f7 = F7_ALT;
			default:                 f7 = F7_BASE;
		endcase
		return f7;
	endfunction

endpackage

`default_nettype wire

[rtl/rvienc_req_if.sv]
// request channel carrying one instruction to encode
`default_nettype none

interface rvienc_req_if;
	logic               valid;
	logic               ready;
	logic [5:0]         action;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic signed [31:0] immediate;
	logic signed [31:0] label_offset;
	logic               target_is_label;

	modport source (
		output valid, action, dest_reg, src1_reg, src2_reg, immediate, label_offset,
			target_is_label,
		input  ready
	);

	modport sink (
		input  valid, action, dest_reg, src1_reg, src2_reg, immediate, label_offset,
			target_is_label,
		output ready
	);
endinterface

`default_nettype wire

[rtl/rvienc_rsp_if.sv]
// response channel carrying one encoded machine word
`default_nettype none

interface rvienc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] machine_word;
	logic        bad_mnemonic;

	modport source (
		output valid, machine_word, bad_mnemonic,
		input  ready
	);

	modport sink (
		input  valid, machine_word, bad_mnemonic,
		output ready
	);
endinterface

`default_nettype wire

[rtl/rvienc_pack.sv]
// field lookup and bit packing of one rv32i instruction
`default_nettype none

module rvienc_pack (
	input  rvienc_pkg::in_item_t  item,
	output rvienc_pkg::out_item_t result
);
	import rvienc_pkg::*;

	mnem_t       code;
	fmt_t        fmt;
	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm;
	logic [31:0] tgt;
	logic [4:0]  rd;
	logic [4:0]  rs1;
	logic [4:0]  rs2;

	// table lookups
	assign code = mnem_t'(item.action);
	assign fmt  = get_format(code);
	assign op   = get_opcode(code);
	assign f3   = get_funct3(code);
	assign f7   = get_funct7(code);
	assign imm  = item.immediate;
	assign rd   = item.dest_reg;
	assign rs1  = item.src1_reg;
	assign rs2  = item.src2_reg;

	// branch and jump offset source
	assign tgt = item.target_is_label ? item.label_offset : item.immediate;

	// packing per layout
	always_comb begin
		result.bad_mnemonic = 1'b0;
		case (fmt)
			FMT_R:     result.machine_word = {f7, rs2, rs1, f3, rd, op};
			FMT_SHIFT: result.machine_word = {f7, imm[4:0], rs1, f3, rd, op};
			FMT_I:     result.machine_word = {imm[11:0], rs1, f3, rd, op};
			FMT_S:     result.machine_word = {imm[11:5], rs2, rs1, f3, imm[4:0], op};
			FMT_B:     result.machine_word = {tgt[12], tgt[10:5], rs2, rs1, f3,
				tgt[4:1], tgt[11], op};
			FMT_U:     result.machine_word = {imm[19:0], rd, op};
			FMT_J:     result.machine_word = {tgt[20], tgt[10:1], tgt[11], tgt[19:12],
				rd, op};
			default: begin
				result.machine_word = '0;
				result.bad_mnemonic = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/rv32i_instruction_encoder.sv]
// RV32I instruction encoder: resolved instruction in, 32-bit machine word out
// Channels: req carries one resolved instruction (mnemonic code, rd, rs1, rs2,
//   immediate, label offset and label select); rsp carries the encoded machine
//   word and a flag for an unknown mnemonic code (word is then zero).
// Both channels use valid/ready; a transaction happens on a rising edge with
//   valid and ready high.
// Path: a transaction taken sits in the input register (_s1), is encoded by the
//   table lookup and packing logic and moves to the result register (_s2) once
//   that is empty or rsp takes its result; rsp.valid is high while _s2 is full.
// Throughput: one instruction per cycle while rsp is not stalled; holds up to two
//   and fills an empty input register while a finished result waits on rsp.
// Stall: when rsp.ready is low a full result register holds; the input register
//   holds once the result register is full and rsp.ready is low, and req.ready drops
//   only when both registers are full and rsp.ready is low.
// Reset: arst_n low clears both stage valid flags at once; nothing is in flight.
`default_nettype none

module rv32i_instruction_encoder (
	input  wire          clk,
	input  wire          arst_n,
	rvienc_req_if.sink   req,
	rvienc_rsp_if.source rsp
);
	import rvienc_pkg::*;

	in_item_t  item_in;
	in_item_t  item_s1;
	out_item_t res_comb;
	out_item_t res_s2;
	logic      vld_s1;
	logic      vld_s2;
	logic      adv_s2;
	logic      adv_s1;

	// handshake control
	assign adv_s2    = !vld_s2 || rsp.ready;
	assign adv_s1    = !vld_s1 || adv_s2;
	assign req.ready = adv_s1;

	// request payload gathered into a struct
	assign item_in = '{
		action:          req.action,
		dest_reg:        req.dest_reg,
		src1_reg:        req.src1_reg,
		src2_reg:        req.src2_reg,
		immediate:       req.immediate,
		label_offset:    req.label_offset,
		target_is_label: req.target_is_label
	};

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= req.valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) item_s1 <= item_in;
	end

	// encode logic
	rvienc_pack u_pack (
		.item   (item_s1),
		.result (res_comb)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) res_s2 <= res_comb;
	end

	assign rsp.valid        = vld_s2;
	assign rsp.machine_word = res_s2.machine_word;
	assign rsp.bad_mnemonic = res_s2.bad_mnemonic;

	// an unknown mnemonic always comes with a zero word
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.bad_mnemonic |-> res_s2.machine_word == '0)
		else $error("bad mnemonic with nonzero machine word");

	// an accepted transaction always lands in the input register
	a_take_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_s1)
		else $error("accepted transaction lost at input register");

	// a stalled input register keeps its contents
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv_s2 |=> vld_s1 && $stable(item_s1))
		else $error("input register changed while stalled");

	// a full input register moves on when the result register frees up
	a_move_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s2 |=> vld_s2)
		else $error("encoded result dropped");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench of the rv32i instruction encoder
`timescale 1ns / 100ps

module tb_top;
	import rvienc_pkg::*;

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   sink_idle_pct;

	rvienc_req_if req_ch ();
	rvienc_rsp_if rsp_ch ();

	rv32i_instruction_encoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// expected machine words and their comparison with the response channel
	class encode_scoreboard;
		out_item_t pending_words[$];
		int        errors;

		function new();
			errors = 0;
		endfunction

		// encode one instruction word from the base isa tables
		function out_item_t encode_word(in_item_t t);
			logic [6:0]  op;
			logic [6:0]  f7;
			logic [2:0]  f3;
			logic [31:0] imm;
			logic [31:0] ofs;
			logic [4:0]  rd;
			logic [4:0]  rs1;
			logic [4:0]  rs2;
			out_item_t   r;
			imm = t.immediate;
			ofs = t.target_is_label ? t.label_offset : t.immediate;
			rd  = t.dest_reg;
			rs1 = t.src1_reg;
			rs2 = t.src2_reg;
			op  = '0;
			f3  = F3_0;
			f7  = F7_BASE;
			case (t.action)
				MN_ADD:   {op, f3} = {OP_REG, F3_0};
				MN_SUB:   {op, f3} = {OP_REG, F3_0};
				MN_SLL:   {op, f3} = {OP_REG, F3_1};
				MN_SLT:   {op, f3} = {OP_REG, F3_2};
				MN_SLTU:  {op, f3} = {OP_REG, F3_3};
				MN_XOR:   {op, f3} = {OP_REG, F3_4};
				MN_SRL:   {op, f3} = {OP_REG, F3_5};
				MN_SRA:   {op, f3} = {OP_REG, F3_5};
				MN_OR:    {op, f3} = {OP_REG, F3_6};
				MN_AND:   {op, f3} = {OP_REG, F3_7};
				MN_ADDI:  {op, f3} = {OP_IMM, F3_0};
				MN_SLTI:  {op, f3} = {OP_IMM, F3_2};
				MN_SLTIU: {op, f3} = {OP_IMM, F3_3};
				MN_XORI:  {op, f3} = {OP_IMM, F3_4};
				MN_ORI:   {op, f3} = {OP_IMM, F3_6};
				MN_ANDI:  {op, f3} = {OP_IMM, F3_7};
				MN_SLLI:  {op, f3} = {OP_IMM, F3_1};
				MN_SRLI:  {op, f3} = {OP_IMM, F3_5};
				MN_SRAI:  {op, f3} = {OP_IMM, F3_5};
				MN_LB:    {op, f3} = {OP_LOAD, F3_0};
				MN_LH:    {op, f3} = {OP_LOAD, F3_1};
				MN_LW:    {op, f3} = {OP_LOAD, F3_2};
				MN_LBU:   {op, f3} = {OP_LOAD, F3_4};
				MN_LHU:   {op, f3} = {OP_LOAD, F3_5};
				MN_JALR:  {op, f3} = {OP_JALR, F3_0};
				MN_SB:    {op, f3} = {OP_STORE, F3_0};
				MN_SH:    {op, f3} = {OP_STORE, F3_1};
				MN_SW:    {op, f3} = {OP_STORE, F3_2};
				MN_BEQ:   {op, f3} = {OP_BRANCH, F3_0};
				MN_BNE:   {op, f3} = {OP_BRANCH, F3_1};
				MN_BLT:   {op, f3} = {OP_BRANCH, F3_4};
				MN_BGE:   {op, f3} = {OP_BRANCH, F3_5};
				MN_BLTU:  {op, f3} = {OP_BRANCH, F3_6};
				MN_BGEU:  {op, f3} = {OP_BRANCH, F3_7};
				MN_LUI:   {op, f3} = {OP_LUI, F3_0};
				MN_AUIPC: {op, f3} = {OP_AUIPC, F3_0};
				MN_JAL:   {op, f3} = {OP_JAL, F3_0};
				default:  {op, f3} = {7'b0, F3_0};
			endcase
			// subtract and arithmetic shifts take the alternate funct7
			if (t.action == MN_SUB || t.action == MN_SRA || t.action == MN_SRAI)
				f7 = F7_ALT;
			r.bad_mnemonic = 1'b0;
			// pack by layout
			if (t.action > MN_JAL) begin
				r.machine_word = '0;
				r.bad_mnemonic = 1'b1;
			end else if (t.action <= MN_AND)
				r.machine_word = {f7, rs2, rs1, f3, rd, op};
			else if (t.action >= MN_SLLI && t.action <= MN_SRAI)
				r.machine_word = {f7, imm[4:0], rs1, f3, rd, op};
			else if (t.action <= MN_JALR)
				r.machine_word = {imm[11:0], rs1, f3, rd, op};
			else if (t.action <= MN_SW)
				r.machine_word = {imm[11:5], rs2, rs1, f3, imm[4:0], op};
			else if (t.action <= MN_BGEU)
				r.machine_word = {ofs[12], ofs[10:5], rs2, rs1, f3, ofs[4:1], ofs[11], op};
			else if (t.action <= MN_AUIPC)
				r.machine_word = {imm[19:0], rd, op};
			else
				r.machine_word = {ofs[20], ofs[10:1], ofs[11], ofs[19:12], rd, op};
			return r;
		endfunction

		function void note_input(in_item_t t);
			pending_words.insert(pending_words.size(), encode_word(t));
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		function void check_result(logic [31:0] word, logic bad);
			out_item_t want;
			if (pending_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual word %h bad %b",
					$time, word, bad);
				return;
			end
			want = pending_words.pop_front();
			if (word !== want.machine_word) begin
				errors++;
				$display("%0t: machine_word mismatch: expected %h, actual %h",
					$time, want.machine_word, word);
			end
			if (bad !== want.bad_mnemonic) begin
				errors++;
				$display("%0t: bad_mnemonic mismatch: expected %b, actual %b",
					$time, want.bad_mnemonic, bad);
			end
		endfunction
	endclass

	encode_scoreboard board;

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// random operand value, biased toward small values and extremes
	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(3))
			0:       v = 32'($urandom_range(4095)) - 32'd2048;
			1: begin
				case ($urandom_range(3))
					0:       v = 32'h7FFF_FFFF;
					1:       v = 32'h8000_0000;
					2:       v = 32'hFFFF_FFFF;
					default: v = 32'h0;
				endcase
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic in_item_t random_instr();
		in_item_t t;
		if ($urandom_range(9) == 0)
			t.action = 6'($urandom_range(63, 37));
		else
			t.action = 6'($urandom_range(36));
		t.dest_reg        = 5'($urandom_range(31));
		t.src1_reg        = 5'($urandom_range(31));
		t.src2_reg        = 5'($urandom_range(31));
		t.immediate       = pick_value();
		t.label_offset    = pick_value();
		t.target_is_label = 1'($urandom_range(1));
		return t;
	endfunction

	// offer one instruction and wait for its transaction
	task automatic send_instr(input in_item_t t);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.action          <= t.action;
		req_ch.dest_reg        <= t.dest_reg;
		req_ch.src1_reg        <= t.src1_reg;
		req_ch.src2_reg        <= t.src2_reg;
		req_ch.immediate       <= t.immediate;
		req_ch.label_offset    <= t.label_offset;
		req_ch.target_is_label <= t.target_is_label;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		board.note_input(t);
	endtask

	// response side: check each transaction, stall at random
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			board.check_result(rsp_ch.machine_word, rsp_ch.bad_mnemonic);
		rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// stimulus and end of run
	initial begin : stimulus
		in_item_t    item;
		logic [31:0] edge_val;
		board         = new();
		src_idle_pct  = 11;
		sink_idle_pct = 63;
		arst_n        = 1'b0;
		req_ch.valid           <= 1'b0;
		req_ch.action          <= '0;
		req_ch.dest_reg        <= '0;
		req_ch.src1_reg        <= '0;
		req_ch.src2_reg        <= '0;
		req_ch.immediate       <= '0;
		req_ch.label_offset    <= '0;
		req_ch.target_is_label <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every mnemonic with extreme operands, then unknown codes
		for (int code = 0; code <= 38; code++) begin
			case (code % 4)
				0:       edge_val = 32'h7FFF_FFFF;
				1:       edge_val = 32'h8000_0000;
				2:       edge_val = 32'hFFFF_FFFF;
				default: edge_val = 32'h0000_0001;
			endcase
			item.action          = (code == 37) ? 6'd37 : (code == 38) ? 6'd63 : 6'(code);
			item.dest_reg        = code[0] ? 5'd31 : 5'd0;
			item.src1_reg        = code[0] ? 5'd0 : 5'd31;
			item.src2_reg        = code[1] ? 5'd31 : 5'd0;
			item.immediate       = edge_val;
			item.label_offset    = ~edge_val;
			item.target_is_label = code[0];
			send_instr(item);
		end

		// three random phases with different idle patterns
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin src_idle_pct = 11; sink_idle_pct = 63; end
				1:       begin src_idle_pct = 63; sink_idle_pct = 11; end
				default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
			endcase
			repeat (290) send_instr(random_instr());
		end
		req_ch.valid <= 1'b0;

		// drain the pipeline, then allow for stray results
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
